FILE: rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m: label");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m: label");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: rtl/rcp_pkg.sv
`default_nettype none
package rcp_pkg;
  localparam int unsigned MaxChunks = 256;
  localparam logic [31:0] WordFresh = 32'd3;
  localparam logic [31:0] RefUnit = 32'd2;
  localparam logic [31:0] InuseOnly = 32'd1;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0, CMD_RETAIN = 3'd1, CMD_RELEASE = 3'd2,
    CMD_ADDREFS = 3'd3, CMD_TOADDR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_BASE = 2'd0, REG_BYTES = 2'd1, REG_COUNT = 2'd2
  } reg_e;

  // front unit: divide state
  typedef enum logic [1:0] {FS_IDLE, FS_DIV, FS_PUSH} fstate_e;
  // back unit: table work
  typedef enum logic [2:0] {BS_IDLE, BS_SCAN, BS_READ, BS_MUL, BS_OUT} bstate_e;

  // classified job handed from front to back
  typedef struct packed {
    logic [2:0]  cmd;
    logic        valid_idx;
    logic [11:0] idx;
    logic [31:0] radd;
  } job_t;
endpackage
`default_nettype wire

FILE: rtl/rcp_front.sv
`default_nettype none
`include "assert_macros.svh"
module rcp_front #(
  parameter int unsigned MaxChunks = rcp_pkg::MaxChunks,
  parameter int unsigned CapW = $clog2(MaxChunks + 1)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              stall_o,
  input  wire logic [2:0]   cmd_i,
  input  wire logic [31:0]  chunk_addr_i,
  input  wire logic [11:0]  chunk_index_i,
  input  wire logic [31:0]  ref_add_i,
  input  wire logic [31:0]  base_i,
  input  wire logic [20:0]  bytes_i,
  input  wire logic [CapW-1:0] cap_i,
  output logic              job_valid_o,
  input  wire logic         job_stall_i,
  output rcp_pkg::job_t     job_o
);
  rcp_pkg::fstate_e state_q, state_d;
  rcp_pkg::job_t job_q, job_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d;
  logic [5:0] cnt_q, cnt_d;
  logic [32:0] trial;
  logic addr_ok;
  logic [31:0] diff;

  assign diff = chunk_addr_i - base_i;
  assign addr_ok = (chunk_addr_i != 32'd0) && (chunk_addr_i >= base_i) &&
                   (bytes_i != 21'd0);
  // restoring divide, one quotient bit a cycle
  assign trial = {rem_q[30:0], quo_q[31]} - {12'd0, bytes_i};

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcp_pkg::FS_IDLE: if (valid_i) begin
        if (cmd_i == rcp_pkg::CMD_RETAIN || cmd_i == rcp_pkg::CMD_RELEASE) begin
          state_d = addr_ok ? rcp_pkg::FS_DIV : rcp_pkg::FS_PUSH;
        end else begin
          state_d = rcp_pkg::FS_PUSH;
        end
      end
      rcp_pkg::FS_DIV: if (cnt_q == 6'd31) state_d = rcp_pkg::FS_PUSH;
      rcp_pkg::FS_PUSH: if (!job_stall_i) state_d = rcp_pkg::FS_IDLE;
      default: state_d = rcp_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    job_d = job_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    case (state_q)
      rcp_pkg::FS_IDLE: begin
        job_d.cmd = cmd_i;
        job_d.radd = ref_add_i;
        job_d.idx = chunk_index_i;
        // only index commands carry a usable index; undefined commands answer not ok
        job_d.valid_idx = 1'b0;
        if (cmd_i inside {rcp_pkg::CMD_ADDREFS, rcp_pkg::CMD_TOADDR})
          job_d.valid_idx = ({20'd0, chunk_index_i} < {{(32-CapW){1'b0}}, cap_i});
        rem_d = 32'd0;
        quo_d = diff;
        cnt_d = 6'd0;
      end
      rcp_pkg::FS_DIV: begin
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], quo_q[31]};
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          job_d.valid_idx = (quo_d < {{(32-CapW){1'b0}}, cap_i});
          job_d.idx = quo_d[11:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rcp_pkg::FS_IDLE;
    else state_q <= state_d;
  end
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  assign stall_o = (state_q != rcp_pkg::FS_IDLE);
  assign job_valid_o = (state_q == rcp_pkg::FS_PUSH);
  assign job_o = job_q;

  `ASSERT_CLK(a_div_len, clk_i, rst_ni,
    (state_q == rcp_pkg::FS_DIV && cnt_q == 6'd31) |=> state_q == rcp_pkg::FS_PUSH)
  `ASSERT_CLK(a_push_hold, clk_i, rst_ni,
    (job_valid_o && job_stall_i) |=> job_valid_o && $stable(job_o))
  `ASSERT_NEVER(a_idle_push, clk_i, rst_ni, stall_o == 1'b0 && job_valid_o)
endmodule
`default_nettype wire

FILE: rtl/rcp_back.sv
`default_nettype none
`include "assert_macros.svh"
module rcp_back #(
  parameter int unsigned MaxChunks = rcp_pkg::MaxChunks,
  parameter int unsigned CapW = $clog2(MaxChunks + 1),
  parameter int unsigned IdxW = (MaxChunks > 1) ? $clog2(MaxChunks) : 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         job_valid_i,
  output logic              job_stall_o,
  input  rcp_pkg::job_t     job_i,
  input  wire logic [31:0]  base_i,
  input  wire logic [20:0]  bytes_i,
  input  wire logic [CapW-1:0] cap_i,
  output logic              valid_o,
  input  wire logic         stall_i,
  output logic              ok_o,
  output logic [31:0]       result_addr_o,
  output logic [11:0]       result_index_o,
  output logic [31:0]       state_after_o
);
  rcp_pkg::bstate_e state_q, state_d;
  logic [31:0] mem [MaxChunks];
  logic [MaxChunks-1:0] vld_q;
  rcp_pkg::job_t job_q;
  logic [CapW-1:0] ptr_q, ptr_d;
  logic [31:0] rd_q, word_q, word_d;
  logic ok_q, ok_d;
  logic [11:0] idx_q, idx_d;
  logic [52:0] prod_q;
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0] wdata, cur;
  logic out_v_q;
  logic [31:0] addr_q;

  assign cur = vld_q[raddr] ? rd_q : 32'd0;
  assign raddr = idx_q[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcp_pkg::BS_IDLE: if (job_valid_i) begin
        if (job_i.cmd == rcp_pkg::CMD_ALLOC) state_d = rcp_pkg::BS_SCAN;
        else if (job_i.valid_idx) state_d = rcp_pkg::BS_READ;
        else state_d = rcp_pkg::BS_OUT;
      end
      rcp_pkg::BS_SCAN:
        if (ptr_q >= cap_i || (vld_q[ptr_q[IdxW-1:0]] ? 1'b0 : 1'b1) ||
            ptr_q == CapW'(MaxChunks - 1))
          state_d = rcp_pkg::BS_READ;
      rcp_pkg::BS_READ: state_d = rcp_pkg::BS_MUL;
      rcp_pkg::BS_MUL: state_d = rcp_pkg::BS_OUT;
      rcp_pkg::BS_OUT: if (!out_v_q || !stall_i) state_d = rcp_pkg::BS_IDLE;
      default: state_d = rcp_pkg::BS_IDLE;
    endcase
  end

  // scan relies on valid bits: a written word of zero is cleared from vld
  always_comb begin
    ptr_d = ptr_q;
    ok_d = ok_q;
    idx_d = idx_q;
    word_d = word_q;
    we = 1'b0;
    wdata = 32'd0;
    waddr = raddr;
    case (state_q)
      rcp_pkg::BS_IDLE: begin
        ptr_d = '0;
        ok_d = job_i.valid_idx;
        idx_d = job_i.idx;
      end
      rcp_pkg::BS_SCAN: begin
        idx_d = 12'(ptr_q);
        ok_d = 1'b0;
        if (ptr_q < cap_i && !vld_q[ptr_q[IdxW-1:0]]) ok_d = 1'b1;
        else if (ptr_q < cap_i && ptr_q != CapW'(MaxChunks - 1)) ptr_d = ptr_q + 1'b1;
      end
      rcp_pkg::BS_READ: begin
        word_d = cur;
        if (ok_q) begin
          we = 1'b1;
          case (job_q.cmd)
            rcp_pkg::CMD_ALLOC: wdata = rcp_pkg::WordFresh;
            rcp_pkg::CMD_RETAIN: wdata = cur + rcp_pkg::RefUnit;
            rcp_pkg::CMD_RELEASE: begin
              wdata = cur - rcp_pkg::RefUnit;
              if (cur[31:1] == 31'd1 && wdata == rcp_pkg::InuseOnly) wdata = 32'd0;
            end
            rcp_pkg::CMD_ADDREFS: wdata = cur + {job_q.radd[30:0], 1'b0};
            default: wdata = cur;
          endcase
          word_d = wdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcp_pkg::BS_IDLE;
      vld_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we) vld_q[waddr] <= (wdata != 32'd0);
      if (state_q == rcp_pkg::BS_OUT && (!out_v_q || !stall_i)) out_v_q <= 1'b1;
      else if (!stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[idx_d[IdxW-1:0]];
    ptr_q <= ptr_d;
    ok_q <= ok_d;
    idx_q <= idx_d;
    word_q <= word_d;
    if (state_q == rcp_pkg::BS_IDLE && job_valid_i) job_q <= job_i;
    prod_q <= {41'd0, idx_q} * {32'd0, bytes_i};
    if (state_q == rcp_pkg::BS_OUT && (!out_v_q || !stall_i)) begin
      ok_o <= ok_q;
      addr_q <= ok_q ? base_i + prod_q[31:0] : 32'd0;
      result_index_o <= ok_q ? idx_q : 12'd0;
      state_after_o <= ok_q ? word_q : 32'd0;
    end
  end

  assign result_addr_o = addr_q;
  assign valid_o = out_v_q;
  assign job_stall_o = (state_q != rcp_pkg::BS_IDLE);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    (valid_o && stall_i) |=> valid_o && $stable(state_after_o))
  `ASSERT_NEVER(a_bad_ok, clk_i, rst_ni,
    valid_o && !ok_o && (result_addr_o != 32'd0 || state_after_o != 32'd0))
  `ASSERT_CLK(a_read_mul, clk_i, rst_ni,
    state_q == rcp_pkg::BS_READ |=> state_q == rcp_pkg::BS_MUL)
endmodule
`default_nettype wire

FILE: rtl/refcounted_chunk_pool.sv
`default_nettype none
// pool of fixed-size chunks with reference-counted state words. a front unit
// checks retain/release addresses and divides their offset from base by
// chunk_bytes with a restoring divider; a back unit scans, reads and writes the
// state table. allocate scans first (one chunk a cycle up to capacity); then the
// back unit reads, multiplies and outputs; a command rejected before the table
// (bad address, bad index, undefined command) goes straight to output. one beat
// in flight at a time per unit; the front takes the next beat once the back has
// its job, and the output register holds a result while stalled.
module refcounted_chunk_pool #(
  parameter int unsigned MaxChunks = rcp_pkg::MaxChunks
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [31:0] chunk_addr_i,
  input  wire logic [11:0] chunk_index_i,
  input  wire logic [31:0] ref_add_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic             ok_o,
  output logic [31:0]      result_addr_o,
  output logic [11:0]      result_index_o,
  output logic [31:0]      state_after_o
);
  localparam int unsigned CapW = $clog2(MaxChunks + 1);
  logic [31:0] base_q;
  logic [20:0] bytes_q;
  logic [8:0] count_q;
  logic [CapW-1:0] cap;
  logic job_valid, job_stall;
  rcp_pkg::job_t job;

  assign cap = ({23'd0, count_q} > 32'(MaxChunks)) ? CapW'(MaxChunks) : CapW'(count_q);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
      bytes_q <= 21'd64;
      count_q <= 9'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        rcp_pkg::REG_BASE: base_q <= pwdata;
        rcp_pkg::REG_BYTES: bytes_q <= pwdata[20:0];
        rcp_pkg::REG_COUNT: count_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rcp_pkg::REG_BASE: prdata = base_q;
      rcp_pkg::REG_BYTES: prdata = {11'd0, bytes_q};
      rcp_pkg::REG_COUNT: prdata = {23'd0, count_q};
      default: prdata = 32'd0;
    endcase
  end

  rcp_front #(.MaxChunks(MaxChunks), .CapW(CapW)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .cmd_i, .chunk_addr_i, .chunk_index_i,
    .ref_add_i, .base_i(base_q), .bytes_i(bytes_q), .cap_i(cap),
    .job_valid_o(job_valid), .job_stall_i(job_stall), .job_o(job)
  );

  rcp_back #(.MaxChunks(MaxChunks), .CapW(CapW)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_stall_o(job_stall), .job_i(job),
    .base_i(base_q), .bytes_i(bytes_q), .cap_i(cap), .valid_o, .stall_i, .ok_o,
    .result_addr_o, .result_index_o, .state_after_o
  );
endmodule
`default_nettype wire
